@@ sv/rsup_pkg.sv @@
// ---------------------------------------------------------------------------
// Ride supervisor package
// Widths, reset values, register indexes and codes shared by the supervisor.
// ---------------------------------------------------------------------------
package rsup_pkg;

    // Field widths
    localparam int SAMPLE_W   = 8;
    localparam int THROTTLE_W = 8;
    localparam int PICTURE_W  = 4;
    localparam int BEEP_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Register widths
    localparam int BAND_W     = 6;
    localparam int LIMIT_W    = 5;
    localparam int USAGE_W    = 6;
    localparam int TSTEP_W    = 5;
    localparam int FLOOR_W    = 8;
    localparam int BSTEP_W    = 5;
    localparam int FIRST_W    = 8;
    localparam int STRIDE_W   = 5;

    // Parameter defaults
    localparam int AVG_LOG2_DEF     = 3;
    localparam int PEDAL_LEVELS_DEF = 10;

    // Battery bar picture has a fixed number of levels
    localparam int BAR_LEVELS = 8;

    // Register reset values
    localparam logic [BAND_W-1:0]   RST_RISE_BAND   = 6'd19;
    localparam logic [LIMIT_W-1:0]  RST_DEB_LIMIT   = 5'd20;
    localparam logic [USAGE_W-1:0]  RST_USAGE_HOLD  = 6'd40;
    localparam logic [TSTEP_W-1:0]  RST_TSTEP       = 5'd25;
    localparam logic [FLOOR_W-1:0]  RST_BAT_FLOOR   = 8'd174;
    localparam logic [BSTEP_W-1:0]  RST_BAT_STEP    = 5'd5;
    localparam logic [FIRST_W-1:0]  RST_PED_FIRST   = 8'd30;
    localparam logic [STRIDE_W-1:0] RST_PED_STRIDE  = 5'd20;

    // Picture codes (bar levels 1..8 lie between these)
    localparam logic [PICTURE_W-1:0] PIC_LOW      = 4'd0;
    localparam logic [PICTURE_W-1:0] PIC_CHARGING = 4'd9;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PEDAL_RISE_BAND = 3'd0,
        CFG_DEBOUNCE_LIMIT  = 3'd1,
        CFG_USAGE_HOLD      = 3'd2,
        CFG_THROTTLE_STEP   = 3'd3,
        CFG_BATTERY_FLOOR   = 3'd4,
        CFG_BATTERY_STEP    = 3'd5,
        CFG_PEDAL_FIRST     = 3'd6,
        CFG_PEDAL_STRIDE    = 3'd7
    } t_cfg_idx;

    // Beep codes
    typedef enum logic [BEEP_W-1:0] {
        BEEP_NONE   = 2'd0,
        BEEP_SINGLE = 2'd1,
        BEEP_DOUBLE = 2'd2
    } t_beep;

endpackage

@@ sv/ride_supervisor_tick.sv @@
// ---------------------------------------------------------------------------
// Ride supervisor tick
// Charger, battery gauge, pedal quantizer, reverse debounce and drive lock.
// ---------------------------------------------------------------------------
// One input word is one supervisor tick. The block takes a word in every
// cycle while o_in_ready is high and returns one result word per tick:
// the tick lands in an input register, all checks of that tick (battery
// average and bar compares, pedal thresholds, reverse debounce, lock and
// throttle) run side by side in one pass, and the result and the updated
// supervisor state load together into the result register once it is free.
// The result register keeps taking new words while a finished result waits,
// as long as the consumer frees it in the same cycle. Registers are to be
// written through the plain write port only while no tick is in flight,
// which the block does not enforce; they reset to their documented defaults.
module ride_supervisor_tick #(
    parameter int AVG_LOG2     = rsup_pkg::AVG_LOG2_DEF,
    parameter int PEDAL_LEVELS = rsup_pkg::PEDAL_LEVELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [rsup_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rsup_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // tick input
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [rsup_pkg::SAMPLE_W-1:0]       i_battery_sample,
    input  logic [rsup_pkg::SAMPLE_W-1:0]       i_pedal_sample,
    input  logic                                i_charger_pin,
    input  logic                                i_reverse_pin,
    input  logic                                i_drove_forward,
    input  logic                                i_drove_backward,
    // result output
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [rsup_pkg::THROTTLE_W-1:0]     o_throttle_level,
    output logic                                o_reverse_on,
    output logic                                o_charging,
    output logic                                o_battery_low,
    output logic                                o_drive_locked,
    output logic                                o_aux_power,
    output logic                                o_show_picture,
    output logic [rsup_pkg::PICTURE_W-1:0]      o_picture,
    output logic [rsup_pkg::BEEP_W-1:0]         o_charger_beep,
    output logic [rsup_pkg::BEEP_W-1:0]         o_reverse_beep
);
    import rsup_pkg::*;

    localparam int AVG_N   = 1 << AVG_LOG2;
    localparam int SUM_W   = SAMPLE_W + AVG_LOG2;
    localparam int CNT_W   = AVG_LOG2 + 1;
    localparam int IDX_W   = $clog2(PEDAL_LEVELS + 1);
    localparam int PROD_W  = IDX_W + TSTEP_W;
    localparam int PTHR_W  = 10;
    localparam int BTHR_W  = 9;
    localparam int BARC_W  = $clog2(BAR_LEVELS + 1);

    // Configuration registers
    logic [BAND_W-1:0]   r_cfg_band;
    logic [LIMIT_W-1:0]  r_cfg_limit;
    logic [USAGE_W-1:0]  r_cfg_hold;
    logic [TSTEP_W-1:0]  r_cfg_tstep;
    logic [FLOOR_W-1:0]  r_cfg_floor;
    logic [BSTEP_W-1:0]  r_cfg_bstep;
    logic [FIRST_W-1:0]  r_cfg_first;
    logic [STRIDE_W-1:0] r_cfg_stride;

    // Input stage
    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_in_bat;
    logic [SAMPLE_W-1:0] r_in_ped;
    logic                r_in_chg;
    logic                r_in_rev;
    logic                r_in_fwd;
    logic                r_in_bwd;

    // Supervisor state
    logic [SUM_W-1:0]    r_bat_sum,  n_bat_sum;
    logic [CNT_W-1:0]    r_bat_cnt,  n_bat_cnt;
    logic [SAMPLE_W-1:0] r_bat_held, n_bat_held;
    logic [SAMPLE_W-1:0] r_ped_held, n_ped_held;
    logic [LIMIT_W-1:0]  r_rev_hits, n_rev_hits;
    logic [USAGE_W-1:0]  r_fwd_use,  n_fwd_use;
    logic [USAGE_W-1:0]  r_bwd_use,  n_bwd_use;
    logic                r_chg,      n_chg;
    logic                r_low,      n_low;
    logic                r_lock,     n_lock;
    logic                r_rev,      n_rev;
    logic                r_aux,      n_aux;

    // Result stage
    logic                  r_out_valid;
    logic [THROTTLE_W-1:0] r_out_thr,   n_out_thr;
    logic                  r_out_show,  n_out_show;
    logic [PICTURE_W-1:0]  r_out_pic,   n_out_pic;
    t_beep                 r_out_cbeep, n_out_cbeep;
    t_beep                 r_out_rbeep, n_out_rbeep;
    logic                  r_out_rev;
    logic                  r_out_chg;
    logic                  r_out_low;
    logic                  r_out_lock;
    logic                  r_out_aux;

    // Datapath helpers
    logic [BTHR_W-1:0]   bar_thr [BAR_LEVELS];
    logic [PTHR_W-1:0]   ped_thr [PEDAL_LEVELS];
    logic [SAMPLE_W-1:0] avg;
    logic [BARC_W-1:0]   bar_cnt;
    logic [IDX_W-1:0]    ped_idx;
    logic [PROD_W-1:0]   thr_prod;
    logic                in_use;
    logic                out_free;
    logic                advance;

    // Handshake: input register refills when it moves on or is empty
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    // Threshold lanes for the battery bar and the pedal quantizer
    always_comb begin
        for (int k = 0; k < BAR_LEVELS; k++) begin
            bar_thr[k] = BTHR_W'(r_cfg_floor) + BTHR_W'(k) * BTHR_W'(r_cfg_bstep);
        end
        for (int i = 0; i < PEDAL_LEVELS; i++) begin
            ped_thr[i] = PTHR_W'(r_cfg_first) + PTHR_W'(i) * PTHR_W'(r_cfg_stride);
        end
    end

    // One tick: compute next state and result
    always_comb begin
        n_bat_sum   = r_bat_sum;
        n_bat_cnt   = r_bat_cnt;
        n_bat_held  = r_bat_held;
        n_ped_held  = r_ped_held;
        n_rev_hits  = r_rev_hits;
        n_chg       = r_chg;
        n_low       = r_low;
        n_lock      = r_lock;
        n_rev       = r_rev;
        n_aux       = r_aux;
        n_out_show  = 1'b0;
        n_out_pic   = PIC_LOW;
        n_out_cbeep = BEEP_NONE;
        n_out_rbeep = BEEP_NONE;
        n_out_thr   = '0;
        bar_cnt     = '0;
        ped_idx     = '0;
        thr_prod    = '0;

        // usage counters: reload on drive, then count down
        n_fwd_use = r_in_fwd ? r_cfg_hold : r_fwd_use;
        n_bwd_use = r_in_bwd ? r_cfg_hold : r_bwd_use;
        if (n_fwd_use != '0) begin
            n_fwd_use = n_fwd_use - USAGE_W'(1);
        end
        if (n_bwd_use != '0) begin
            n_bwd_use = n_bwd_use - USAGE_W'(1);
        end
        in_use = (n_fwd_use != '0) || (n_bwd_use != '0);

        // charger plug and unplug
        if (r_chg) begin
            if (!r_in_chg) begin
                n_chg       = 1'b0;
                n_low       = 1'b0;
                n_aux       = 1'b1;
                n_out_cbeep = BEEP_DOUBLE;
            end
        end else if (r_in_chg) begin
            n_chg       = 1'b1;
            n_aux       = 1'b0;
            n_out_show  = 1'b1;
            n_out_pic   = PIC_CHARGING;
            n_out_cbeep = BEEP_SINGLE;
        end

        // battery: accumulate, or spend the rest tick on the average
        avg = r_bat_sum[SUM_W-1:AVG_LOG2];
        for (int k = 0; k < BAR_LEVELS; k++) begin
            if (BTHR_W'(avg) > bar_thr[k]) begin
                bar_cnt = bar_cnt + BARC_W'(1);
            end
        end
        if (r_bat_cnt < CNT_W'(AVG_N)) begin
            n_bat_sum = r_bat_sum + SUM_W'(r_in_bat);
            n_bat_cnt = r_bat_cnt + CNT_W'(1);
        end else begin
            n_bat_sum = '0;
            n_bat_cnt = '0;
            if ((9'(avg) > 9'(r_bat_held) + 9'd1) ||
                (9'(avg) + 9'd1 < 9'(r_bat_held))) begin
                n_bat_held = avg;
                if (!n_chg) begin
                    n_out_show = 1'b1;
                    n_out_pic  = PICTURE_W'(bar_cnt);
                    if (bar_cnt == '0) begin
                        n_low = 1'b1;
                    end
                end
            end
        end

        // pedal: rise past the band, fall at once
        if (9'(r_in_ped) > 9'(r_ped_held) + 9'(r_cfg_band)) begin
            n_ped_held = r_in_ped;
        end else if (r_in_ped < r_ped_held) begin
            n_ped_held = r_in_ped;
        end

        // quantize: thresholds never fall, so count those reached
        for (int i = 0; i < PEDAL_LEVELS; i++) begin
            if (PTHR_W'(n_ped_held) >= ped_thr[i]) begin
                ped_idx = ped_idx + IDX_W'(1);
            end
        end

        // release the lock once the pedal is back at rest
        if (n_lock && ped_idx == '0) begin
            n_lock = 1'b0;
        end

        // reverse switch debounce
        if (!r_in_rev) begin
            if (r_rev) begin
                n_rev_hits  = '0;
                n_rev       = 1'b0;
                if (in_use) begin
                    n_lock = 1'b1;
                end
                n_out_rbeep = BEEP_DOUBLE;
            end
        end else if (!r_rev) begin
            if (r_rev_hits < r_cfg_limit) begin
                n_rev_hits = r_rev_hits + LIMIT_W'(1);
            end else begin
                n_rev       = 1'b1;
                if (in_use) begin
                    n_lock = 1'b1;
                end
                n_out_rbeep = BEEP_SINGLE;
            end
        end

        // throttle with saturation
        thr_prod = PROD_W'(ped_idx) * PROD_W'(r_cfg_tstep);
        if (!(n_chg || n_low || n_lock)) begin
            if (thr_prod > PROD_W'(8'hFF)) begin
                n_out_thr = 8'hFF;
            end else begin
                n_out_thr = thr_prod[THROTTLE_W-1:0];
            end
        end
    end

    // Control, state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_band   <= RST_RISE_BAND;
            r_cfg_limit  <= RST_DEB_LIMIT;
            r_cfg_hold   <= RST_USAGE_HOLD;
            r_cfg_tstep  <= RST_TSTEP;
            r_cfg_floor  <= RST_BAT_FLOOR;
            r_cfg_bstep  <= RST_BAT_STEP;
            r_cfg_first  <= RST_PED_FIRST;
            r_cfg_stride <= RST_PED_STRIDE;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_bat_sum    <= '0;
            r_bat_cnt    <= '0;
            r_bat_held   <= '0;
            r_ped_held   <= '0;
            r_rev_hits   <= '0;
            r_fwd_use    <= '0;
            r_bwd_use    <= '0;
            r_chg        <= 1'b0;
            r_low        <= 1'b0;
            r_lock       <= 1'b0;
            r_rev        <= 1'b0;
            r_aux        <= 1'b1;
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_PEDAL_RISE_BAND: r_cfg_band   <= i_cfg_data[BAND_W-1:0];
                    CFG_DEBOUNCE_LIMIT:  r_cfg_limit  <= i_cfg_data[LIMIT_W-1:0];
                    CFG_USAGE_HOLD:      r_cfg_hold   <= i_cfg_data[USAGE_W-1:0];
                    CFG_THROTTLE_STEP:   r_cfg_tstep  <= i_cfg_data[TSTEP_W-1:0];
                    CFG_BATTERY_FLOOR:   r_cfg_floor  <= i_cfg_data[FLOOR_W-1:0];
                    CFG_BATTERY_STEP:    r_cfg_bstep  <= i_cfg_data[BSTEP_W-1:0];
                    CFG_PEDAL_FIRST:     r_cfg_first  <= i_cfg_data[FIRST_W-1:0];
                    CFG_PEDAL_STRIDE:    r_cfg_stride <= i_cfg_data[STRIDE_W-1:0];
                    default: ;
                endcase
            end

            // input stage valid
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end

            // result stage valid and state commit
            if (advance) begin
                r_out_valid <= 1'b1;
                r_bat_sum   <= n_bat_sum;
                r_bat_cnt   <= n_bat_cnt;
                r_bat_held  <= n_bat_held;
                r_ped_held  <= n_ped_held;
                r_rev_hits  <= n_rev_hits;
                r_fwd_use   <= n_fwd_use;
                r_bwd_use   <= n_bwd_use;
                r_chg       <= n_chg;
                r_low       <= n_low;
                r_lock      <= n_lock;
                r_rev       <= n_rev;
                r_aux       <= n_aux;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_bat <= i_battery_sample;
            r_in_ped <= i_pedal_sample;
            r_in_chg <= i_charger_pin;
            r_in_rev <= i_reverse_pin;
            r_in_fwd <= i_drove_forward;
            r_in_bwd <= i_drove_backward;
        end
        if (advance) begin
            r_out_thr   <= n_out_thr;
            r_out_show  <= n_out_show;
            r_out_pic   <= n_out_pic;
            r_out_cbeep <= n_out_cbeep;
            r_out_rbeep <= n_out_rbeep;
            r_out_rev   <= n_rev;
            r_out_chg   <= n_chg;
            r_out_low   <= n_low;
            r_out_lock  <= n_lock;
            r_out_aux   <= n_aux;
        end
    end

    // Drive outputs
    assign o_out_valid      = r_out_valid;
    assign o_throttle_level = r_out_thr;
    assign o_reverse_on     = r_out_rev;
    assign o_charging       = r_out_chg;
    assign o_battery_low    = r_out_low;
    assign o_drive_locked   = r_out_lock;
    assign o_aux_power      = r_out_aux;
    assign o_show_picture   = r_out_show;
    assign o_picture        = r_out_pic;
    assign o_charger_beep   = r_out_cbeep;
    assign o_reverse_beep   = r_out_rbeep;

    // Checks
    a_aux_off_charging: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_charging |-> !o_aux_power)
        else $error("aux power on while charging");

    a_throttle_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_charging || o_battery_low || o_drive_locked)
        |-> o_throttle_level == '0)
        else $error("throttle driven while charging, low or locked");

    a_no_picture_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_show_picture |-> o_picture == PIC_LOW)
        else $error("picture code without show");

    a_avg_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bat_cnt <= CNT_W'(AVG_N))
        else $error("battery sample count past average length");

    a_state_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_bat_cnt) && $stable(r_ped_held))
        else $error("supervisor state moved without a tick");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Ride supervisor tick testbench
// Sends supervisor ticks over the valid/ready input, predicts the status word
// of each tick with an in-bench model of the supervisor, and compares every
// returned status word field by field. Covers directed corner ticks, default
// and extreme register settings, random settings, stalls on both sides and a
// long consumer hold-off.
// ---------------------------------------------------------------------------
module testbench;
    import rsup_pkg::*;

    localparam int AVG_LOG2     = AVG_LOG2_DEF;
    localparam int PEDAL_LEVELS = PEDAL_LEVELS_DEF;
    localparam int THROTTLE_CAP = (1 << THROTTLE_W) - 1;
    localparam int MAX_CYCLES   = 300000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;
    localparam int NUM_REGS     = 8;

    typedef struct packed {
        logic [SAMPLE_W-1:0] battery;
        logic [SAMPLE_W-1:0] pedal;
        logic                charger_pin;
        logic                reverse_pin;
        logic                drove_forward;
        logic                drove_backward;
    } tick_t;

    typedef struct packed {
        logic [THROTTLE_W-1:0] throttle;
        logic                  reverse_on;
        logic                  charging;
        logic                  battery_low;
        logic                  drive_locked;
        logic                  aux_power;
        logic                  show_picture;
        logic [PICTURE_W-1:0]  picture;
        t_beep                 charger_beep;
        t_beep                 reverse_beep;
    } status_t;

    // DUT ports
    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_cfg_we         = 1'b0;
    t_cfg_idx              i_cfg_idx        = CFG_PEDAL_RISE_BAND;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;
    logic                  i_in_valid       = 1'b0;
    logic                  o_in_ready;
    logic [SAMPLE_W-1:0]   i_battery_sample = '0;
    logic [SAMPLE_W-1:0]   i_pedal_sample   = '0;
    logic                  i_charger_pin    = 1'b0;
    logic                  i_reverse_pin    = 1'b0;
    logic                  i_drove_forward  = 1'b0;
    logic                  i_drove_backward = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready      = 1'b0;
    logic [THROTTLE_W-1:0] o_throttle_level;
    logic                  o_reverse_on;
    logic                  o_charging;
    logic                  o_battery_low;
    logic                  o_drive_locked;
    logic                  o_aux_power;
    logic                  o_show_picture;
    logic [PICTURE_W-1:0]  o_picture;
    logic [BEEP_W-1:0]     o_charger_beep;
    logic [BEEP_W-1:0]     o_reverse_beep;

    // Model registers and supervisor state
    logic [CFG_DATA_W-1:0] cfg_regs [NUM_REGS];
    logic [CFG_DATA_W-1:0] reg_plan [NUM_REGS];
    logic [10:0]           bat_sum;
    logic [3:0]            bat_count;
    logic [7:0]            bat_held;
    logic [7:0]            ped_held;
    logic [4:0]            rev_hits;
    logic [5:0]            fwd_use;
    logic [5:0]            bwd_use;
    logic                  st_charging, st_low, st_lock, st_reverse, aux_on;

    // Bench bookkeeping
    status_t pending_status [$];
    status_t got_word, want_word;
    int      errors       = 0;
    int      cycle_count  = 0;
    bit      idle_on      = 1'b1;
    int      hold_request = 0;
    int      hold_left    = 0;

    // Traffic shaping state
    bit      cord_in       = 1'b0;
    bit      switch_closed = 1'b0;
    int      bat_target    = 200;
    int      ped_last      = 0;

    ride_supervisor_tick DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_battery_sample (i_battery_sample),
        .i_pedal_sample   (i_pedal_sample),
        .i_charger_pin    (i_charger_pin),
        .i_reverse_pin    (i_reverse_pin),
        .i_drove_forward  (i_drove_forward),
        .i_drove_backward (i_drove_backward),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_throttle_level (o_throttle_level),
        .o_reverse_on     (o_reverse_on),
        .o_charging       (o_charging),
        .o_battery_low    (o_battery_low),
        .o_drive_locked   (o_drive_locked),
        .o_aux_power      (o_aux_power),
        .o_show_picture   (o_show_picture),
        .o_picture        (o_picture),
        .o_charger_beep   (o_charger_beep),
        .o_reverse_beep   (o_reverse_beep)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [CFG_DATA_W-1:0] reg_mask(input t_cfg_idx r);
        case (r)
            CFG_PEDAL_RISE_BAND: return CFG_DATA_W'((1 << BAND_W) - 1);
            CFG_DEBOUNCE_LIMIT:  return CFG_DATA_W'((1 << LIMIT_W) - 1);
            CFG_USAGE_HOLD:      return CFG_DATA_W'((1 << USAGE_W) - 1);
            CFG_THROTTLE_STEP:   return CFG_DATA_W'((1 << TSTEP_W) - 1);
            CFG_BATTERY_FLOOR:   return CFG_DATA_W'((1 << FLOOR_W) - 1);
            CFG_BATTERY_STEP:    return CFG_DATA_W'((1 << BSTEP_W) - 1);
            CFG_PEDAL_FIRST:     return CFG_DATA_W'((1 << FIRST_W) - 1);
            default:             return CFG_DATA_W'((1 << STRIDE_W) - 1);
        endcase
    endfunction

    function automatic tick_t make_tick(input logic [7:0] bat, input logic [7:0] ped,
                                        input logic chg, input logic rev,
                                        input logic fwd, input logic bwd);
        tick_t t;
        t.battery        = bat;
        t.pedal          = ped;
        t.charger_pin    = chg;
        t.reverse_pin    = rev;
        t.drove_forward  = fwd;
        t.drove_backward = bwd;
        return t;
    endfunction

    function automatic string fmt_status(input status_t s);
        return $sformatf({"throttle=%0d rev=%0b chg=%0b low=%0b lock=%0b aux=%0b ",
                          "show=%0b pic=%0d cbeep=%0d rbeep=%0d"},
                         s.throttle, s.reverse_on, s.charging, s.battery_low,
                         s.drive_locked, s.aux_power, s.show_picture, s.picture,
                         s.charger_beep, s.reverse_beep);
    endfunction

    // Advance the supervisor state by one tick and return its status word
    function automatic status_t supervise_tick(input tick_t t);
        status_t s;
        int      avg, lvl, idx, prod;
        logic    recent;
        s = '0;
        s.charger_beep = BEEP_NONE;
        s.reverse_beep = BEEP_NONE;

        // reload, then age the usage counters
        if (t.drove_forward)  fwd_use = cfg_regs[CFG_USAGE_HOLD][USAGE_W-1:0];
        if (t.drove_backward) bwd_use = cfg_regs[CFG_USAGE_HOLD][USAGE_W-1:0];
        if (fwd_use != 0) fwd_use--;
        if (bwd_use != 0) bwd_use--;

        // charger plug and unplug; unplug is the only way out of low battery
        if (st_charging) begin
            if (!t.charger_pin) begin
                st_charging    = 1'b0;
                st_low         = 1'b0;
                aux_on         = 1'b1;
                s.charger_beep = BEEP_DOUBLE;
            end
        end else if (t.charger_pin) begin
            st_charging    = 1'b1;
            aux_on         = 1'b0;
            s.show_picture = 1'b1;
            s.picture      = PIC_CHARGING;
            s.charger_beep = BEEP_SINGLE;
        end

        // accumulate samples, or spend the rest tick on the average
        if (int'(bat_count) < (1 << AVG_LOG2)) begin
            bat_sum = bat_sum + t.battery;
            bat_count++;
        end else begin
            avg       = int'(bat_sum) >> AVG_LOG2;
            bat_sum   = '0;
            bat_count = '0;
            if (avg > int'(bat_held) + 1 || avg + 1 < int'(bat_held)) begin
                bat_held = avg[7:0];
                // no gauge picture while the charger is in
                if (!st_charging) begin
                    lvl = 0;
                    for (int k = 0; k < BAR_LEVELS; k++) begin
                        if (avg > int'(cfg_regs[CFG_BATTERY_FLOOR])
                                  + k * int'(cfg_regs[CFG_BATTERY_STEP]))
                            lvl = k + 1;
                    end
                    s.show_picture = 1'b1;
                    s.picture      = lvl[PICTURE_W-1:0];
                    if (s.picture == PIC_LOW) st_low = 1'b1;
                end
            end
        end

        // pedal rises only past the band, falls at once
        if (int'(t.pedal) > int'(ped_held) + int'(cfg_regs[CFG_PEDAL_RISE_BAND]))
            ped_held = t.pedal;
        else if (t.pedal < ped_held)
            ped_held = t.pedal;

        // thresholds never decrease, so count the ones at or below the pedal
        idx = 0;
        for (int i = 0; i < PEDAL_LEVELS; i++) begin
            if (int'(ped_held) >= int'(cfg_regs[CFG_PEDAL_FIRST])
                                  + i * int'(cfg_regs[CFG_PEDAL_STRIDE]))
                idx++;
        end

        // release the lock once the pedal is back at rest
        if (st_lock && idx == 0) st_lock = 1'b0;

        // reverse debounce; an open switch while off keeps the hit count
        recent = (fwd_use != 0) || (bwd_use != 0);
        if (!t.reverse_pin) begin
            if (st_reverse) begin
                rev_hits       = '0;
                st_reverse     = 1'b0;
                if (recent) st_lock = 1'b1;
                s.reverse_beep = BEEP_DOUBLE;
            end
        end else if (!st_reverse) begin
            if (rev_hits < cfg_regs[CFG_DEBOUNCE_LIMIT]) begin
                rev_hits++;
            end else begin
                st_reverse     = 1'b1;
                if (recent) st_lock = 1'b1;
                s.reverse_beep = BEEP_SINGLE;
            end
        end

        // throttle, saturated to the output width
        prod = 0;
        if (!(st_charging || st_low || st_lock)) begin
            prod = idx * int'(cfg_regs[CFG_THROTTLE_STEP]);
            if (prod > THROTTLE_CAP) prod = THROTTLE_CAP;
        end
        s.throttle     = prod[THROTTLE_W-1:0];
        s.reverse_on   = st_reverse;
        s.charging     = st_charging;
        s.battery_low  = st_low;
        s.drive_locked = st_lock;
        s.aux_power    = aux_on;
        return s;
    endfunction

    task automatic reset_model();
        cfg_regs[CFG_PEDAL_RISE_BAND] = CFG_DATA_W'(RST_RISE_BAND);
        cfg_regs[CFG_DEBOUNCE_LIMIT]  = CFG_DATA_W'(RST_DEB_LIMIT);
        cfg_regs[CFG_USAGE_HOLD]      = CFG_DATA_W'(RST_USAGE_HOLD);
        cfg_regs[CFG_THROTTLE_STEP]   = CFG_DATA_W'(RST_TSTEP);
        cfg_regs[CFG_BATTERY_FLOOR]   = CFG_DATA_W'(RST_BAT_FLOOR);
        cfg_regs[CFG_BATTERY_STEP]    = CFG_DATA_W'(RST_BAT_STEP);
        cfg_regs[CFG_PEDAL_FIRST]     = CFG_DATA_W'(RST_PED_FIRST);
        cfg_regs[CFG_PEDAL_STRIDE]    = CFG_DATA_W'(RST_PED_STRIDE);
        bat_sum     = '0;
        bat_count   = '0;
        bat_held    = '0;
        ped_held    = '0;
        rev_hits    = '0;
        fwd_use     = '0;
        bwd_use     = '0;
        st_charging = 1'b0;
        st_low      = 1'b0;
        st_lock     = 1'b0;
        st_reverse  = 1'b0;
        aux_on      = 1'b1;
    endtask

    task automatic note_error(input string msg);
        errors++;
        if (errors <= REPORT_LIMIT) $display("ERROR cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic set_plan(input int band, input int limit, input int usage, input int tstep,
                            input int floor_v, input int bstep, input int first,
                            input int stride);
        reg_plan[CFG_PEDAL_RISE_BAND] = band[7:0];
        reg_plan[CFG_DEBOUNCE_LIMIT]  = limit[7:0];
        reg_plan[CFG_USAGE_HOLD]      = usage[7:0];
        reg_plan[CFG_THROTTLE_STEP]   = tstep[7:0];
        reg_plan[CFG_BATTERY_FLOOR]   = floor_v[7:0];
        reg_plan[CFG_BATTERY_STEP]    = bstep[7:0];
        reg_plan[CFG_PEDAL_FIRST]     = first[7:0];
        reg_plan[CFG_PEDAL_STRIDE]    = stride[7:0];
    endtask

    // Write every register from the plan; dirty sets junk above each width
    task automatic write_regs(input bit dirty);
        t_cfg_idx              r;
        logic [CFG_DATA_W-1:0] m, d, junk;
        for (int i = 0; i < NUM_REGS; i++) begin
            r    = t_cfg_idx'(i);
            m    = reg_mask(r);
            junk = $urandom_range(255);
            d    = reg_plan[i] & m;
            if (dirty) d = d | (junk & ~m);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= r;
            i_cfg_data <= d;
            @(posedge i_clk);
            cfg_regs[r] = d & m;
        end
        i_cfg_we <= 1'b0;
    endtask

    // Offer one tick word and hold it until accepted
    task automatic send_tick(input tick_t t);
        if (idle_on && $urandom_range(99) < 25) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 25);
        end
        i_in_valid       <= 1'b1;
        i_battery_sample <= t.battery;
        i_pedal_sample   <= t.pedal;
        i_charger_pin    <= t.charger_pin;
        i_reverse_pin    <= t.reverse_pin;
        i_drove_forward  <= t.drove_forward;
        i_drove_backward <= t.drove_backward;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_status.push_back(supervise_tick(t));
    endtask

    // Drop valid and wait until every status word is back
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Plausible ride traffic: cord and switch in runs, battery near the floor
    task automatic run_traffic(input int count);
        int b, p;
        bit rev;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 2) cord_in = !cord_in;
            if ($urandom_range(99) < 3) switch_closed = !switch_closed;
            if ($urandom_range(99) < 6)
                bat_target = int'(cfg_regs[CFG_BATTERY_FLOOR]) + int'($urandom_range(60)) - 12;
            if ($urandom_range(9) == 0) b = $urandom_range(255);
            else b = bat_target + int'($urandom_range(4)) - 2;
            b = (b < 0) ? 0 : (b > 255) ? 255 : b;
            case ($urandom_range(9))
                0, 1:    p = 0;
                2:       p = 255;
                3, 4:    p = $urandom_range(255);
                default: p = ped_last + int'($urandom_range(60)) - 30;
            endcase
            p = (p < 0) ? 0 : (p > 255) ? 255 : p;
            ped_last = p;
            // occasional switch bounce
            rev = switch_closed ^ ($urandom_range(99) < 4);
            send_tick(make_tick(b[7:0], p[7:0], cord_in, rev,
                                $urandom_range(99) < 30, $urandom_range(99) < 30));
        end
    endtask

    // Consumer side: random stalls, plus a counted hold-off on request
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !(idle_on && $urandom_range(99) < 25);
        end
    end

    // Check each returned status word against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_word.throttle     = o_throttle_level;
            got_word.reverse_on   = o_reverse_on;
            got_word.charging     = o_charging;
            got_word.battery_low  = o_battery_low;
            got_word.drive_locked = o_drive_locked;
            got_word.aux_power    = o_aux_power;
            got_word.show_picture = o_show_picture;
            got_word.picture      = o_picture;
            got_word.charger_beep = t_beep'(o_charger_beep);
            got_word.reverse_beep = t_beep'(o_reverse_beep);
            if (pending_status.size() == 0) begin
                note_error({"unexpected status word ", fmt_status(got_word)});
            end else begin
                want_word = pending_status.pop_front();
                if (got_word.throttle     !== want_word.throttle     ||
                    got_word.reverse_on   !== want_word.reverse_on   ||
                    got_word.charging     !== want_word.charging     ||
                    got_word.battery_low  !== want_word.battery_low  ||
                    got_word.drive_locked !== want_word.drive_locked ||
                    got_word.aux_power    !== want_word.aux_power    ||
                    got_word.show_picture !== want_word.show_picture ||
                    got_word.picture      !== want_word.picture      ||
                    got_word.charger_beep !== want_word.charger_beep ||
                    got_word.reverse_beep !== want_word.reverse_beep)
                    note_error({"status mismatch\n  expected ", fmt_status(want_word),
                                "\n  actual   ", fmt_status(got_word)});
            end
        end
    end

    // Corner ticks under reset and tight register values
    task automatic test_directed();
        // full window with pedal extremes; plug on the last sample
        send_tick(make_tick(8'd255, 8'd255, 1'b0, 1'b0, 1'b1, 1'b0));
        send_tick(make_tick(8'd255, 8'd0,   1'b0, 1'b0, 1'b0, 1'b1));
        repeat (5) send_tick(make_tick(8'd255, 8'd128, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(8'd255, 8'd128, 1'b1, 1'b0, 1'b0, 1'b0));
        // rest tick while charging: gauge moves but shows nothing
        send_tick(make_tick(8'd0, 8'd0, 1'b1, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(8'd0, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0));
        settle();

        // one-hit debounce, saturating throttle, flat thresholds, top floor
        set_plan(63, 1, 63, 31, 255, 31, 1, 0);
        write_regs(1'b1);
        send_tick(make_tick(8'd0, 8'd0,   1'b0, 1'b1, 1'b1, 1'b1));
        send_tick(make_tick(8'd0, 8'd0,   1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(8'd0, 8'd0,   1'b0, 1'b1, 1'b0, 1'b0));
        send_tick(make_tick(8'd0, 8'd200, 1'b0, 1'b1, 1'b0, 1'b0));
        send_tick(make_tick(8'd0, 8'd0,   1'b0, 1'b0, 1'b0, 1'b0));
        // drive lock holds the throttle at zero, then the rest tick latches low battery
        repeat (9) send_tick(make_tick(8'd0, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0));
        // plug and unplug clear the low latch
        send_tick(make_tick(8'd0, 8'd255, 1'b1, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(8'd0, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0));
        settle();
    endtask

    task automatic test_default_traffic();
        set_plan(RST_RISE_BAND, RST_DEB_LIMIT, RST_USAGE_HOLD, RST_TSTEP,
                 RST_BAT_FLOOR, RST_BAT_STEP, RST_PED_FIRST, RST_PED_STRIDE);
        write_regs(1'b0);
        run_traffic(400);
        settle();
    endtask

    task automatic test_no_idle();
        idle_on = 1'b0;
        run_traffic(400);
        settle();
        idle_on = 1'b1;
    endtask

    // Hold the consumer off while ticks keep coming so the input stalls
    task automatic test_back_pressure();
        hold_request = 300;
        run_traffic(80);
        settle();
    endtask

    task automatic test_config_sweep();
        t_cfg_idx r;
        // all registers at zero
        set_plan(0, 0, 0, 0, 0, 0, 0, 0);
        write_regs(1'b0);
        run_traffic(200);
        settle();
        // all registers at full width
        set_plan(63, 31, 63, 31, 255, 31, 255, 31);
        write_regs(1'b0);
        run_traffic(200);
        settle();
        // random settings with junk in the unused data bits
        repeat (4) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r = t_cfg_idx'(i);
                reg_plan[i] = $urandom_range(255);
                reg_plan[i] = reg_plan[i] & reg_mask(r);
            end
            write_regs(1'b1);
            run_traffic(180);
            settle();
        end
    endtask

    initial begin
        reset_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_default_traffic();
        test_no_idle();
        test_back_pressure();
        test_config_sweep();

        settle();
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ ride_supervisor_tick.f @@
sv/rsup_pkg.sv
sv/ride_supervisor_tick.sv
tb/sv/testbench.sv
